@@ sv/ptds_pkg.sv @@
// Package for the point to triangle squared distance pipeline.
// Holds widths, the region codes, the pipeline side-band struct and vector helpers.
// Used by point_triangle_distance_squared; depends on nothing else.
`default_nettype none

package ptds_pkg;

   localparam int COORD_W   = 16;
   localparam int NUM_COORD = 12;
   localparam int DIFF_W    = 17;
   localparam int PROD_W    = 2 * DIFF_W;
   localparam int DOT_W     = 36;
   localparam int OE_W      = 2 * DOT_W;
   localparam int CRS_W     = 35;
   localparam int MAG_W     = 34;
   localparam int SQ_W      = 2 * MAG_W;
   localparam int SUMSQ_W   = 70;
   localparam int EDEN_W    = 36;
   localparam int T_W       = 52;
   localparam int TMAG_W    = 51;
   localparam int TLO_W     = 26;
   localparam int THI_W     = TMAG_W - TLO_W;
   localparam int NUM_W     = 104;
   localparam int QUO_W     = 34;
   localparam int PRE_STAGES = 6;
   localparam int LAT       = PRE_STAGES + QUO_W;
   localparam int REQ_W     = COORD_W * NUM_COORD;
   localparam int RSP_W     = 40;

   localparam logic [QUO_W-1:0] DIST_MAX = '1;

   typedef enum logic [2:0] {
      REGION_VERT_A,
      REGION_VERT_B,
      REGION_VERT_C,
      REGION_EDGE_AB,
      REGION_EDGE_BC,
      REGION_EDGE_CA,
      REGION_FACE
   } region_type;

   typedef struct packed {
      region_type       region;
      logic             deg;
      logic             use_fix;
      logic [QUO_W-1:0] fix;
   } side_type;

   typedef logic signed [DIFF_W-1:0] vec17_type [3];
   typedef logic signed [CRS_W-1:0]  vec35_type [3];

   function automatic logic signed [DOT_W-1:0] dot17(input vec17_type p, input vec17_type q);
      logic signed [PROD_W-1:0] m0, m1, m2;
      m0 = p[0] * q[0];
      m1 = p[1] * q[1];
      m2 = p[2] * q[2];
      return DOT_W'(m0) + DOT_W'(m1) + DOT_W'(m2);
   endfunction

   function automatic vec35_type cross17(input vec17_type p, input vec17_type q);
      vec35_type r;
      logic signed [PROD_W-1:0] m0, m1, m2, m3, m4, m5;
      m0 = p[1] * q[2];
      m1 = p[2] * q[1];
      m2 = p[2] * q[0];
      m3 = p[0] * q[2];
      m4 = p[0] * q[1];
      m5 = p[1] * q[0];
      r[0] = CRS_W'(m0) - CRS_W'(m1);
      r[1] = CRS_W'(m2) - CRS_W'(m3);
      r[2] = CRS_W'(m4) - CRS_W'(m5);
      return r;
   endfunction

   function automatic logic [MAG_W-1:0] mag35(input logic signed [CRS_W-1:0] x);
      logic signed [CRS_W-1:0] n;
      n = -x;
      return x[CRS_W-1] ? n[MAG_W-1:0] : x[MAG_W-1:0];
   endfunction

endpackage

`default_nettype wire

@@ sv/point_triangle_distance_squared.sv @@
// Streaming point to triangle squared distance, fully pipelined.
// Depends on ptds_pkg for widths, region codes and vector helpers.
//
//   channel | direction | word
//   req_    | in        | tdata: a.xyz, b.xyz, c.xyz, query.xyz, 16 bits each
//   rsp_    | out       | tdata: dist_sq, region, degenerate, zero padding
//
// One word enters per cycle while the output word is taken or the last stage is empty.
// Six stages form differences, dot and cross products, region, divide operands
// and the saturation check, then a restoring divider resolves one quotient bit per stage.
// Reset clears only the stage valid bits. When the output word is not taken,
// every stage holds and req_tready falls in the same cycle.
`default_nettype none

module point_triangle_distance_squared (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_tvalid,
   output logic                       req_tready,
   // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, query_x, query_y, query_z
   input  wire [ptds_pkg::REQ_W-1:0]  req_tdata,
   output logic                       rsp_tvalid,
   input  wire                        rsp_tready,
   // dist_sq[33:0], region[36:34], degenerate[37], zeros[39:38]
   output logic [ptds_pkg::RSP_W-1:0] rsp_tdata
);

   localparam int DW = ptds_pkg::DOT_W;

   logic adv;
   logic [ptds_pkg::LAT-1:0] vld_ff, vld_in;

   assign adv        = !vld_ff[ptds_pkg::LAT-1] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[ptds_pkg::LAT-1];
   assign vld_in     = {vld_ff[ptds_pkg::LAT-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // Stage 1: coordinate differences.
   ptds_pkg::vec17_type pa, pb, pc, pv;
   ptds_pkg::vec17_type ab_ff, ba_ff, bc_ff, cb_ff, ac_ff, ca_ff, av_ff, bv_ff, cv_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pa[i] = ptds_pkg::DIFF_W'($signed(req_tdata[ptds_pkg::COORD_W*i +: ptds_pkg::COORD_W]));
         pb[i] = ptds_pkg::DIFF_W'($signed(req_tdata[ptds_pkg::COORD_W*(i+3) +: ptds_pkg::COORD_W]));
         pc[i] = ptds_pkg::DIFF_W'($signed(req_tdata[ptds_pkg::COORD_W*(i+6) +: ptds_pkg::COORD_W]));
         pv[i] = ptds_pkg::DIFF_W'($signed(req_tdata[ptds_pkg::COORD_W*(i+9) +: ptds_pkg::COORD_W]));
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            ab_ff[i] <= pb[i] - pa[i];
            ba_ff[i] <= pa[i] - pb[i];
            bc_ff[i] <= pc[i] - pb[i];
            cb_ff[i] <= pb[i] - pc[i];
            ac_ff[i] <= pc[i] - pa[i];
            ca_ff[i] <= pa[i] - pc[i];
            av_ff[i] <= pv[i] - pa[i];
            bv_ff[i] <= pv[i] - pb[i];
            cv_ff[i] <= pv[i] - pc[i];
         end
      end
   end

   // Stage 2: dot products, cross products and the face normal.
   // Edge index 0 is ab, 1 is bc, 2 is ca; cross index 3 is the normal.
   logic signed [DW-1:0] dav_ac2_ff, dav_ab2_ff, dbv_ba2_ff, dbv_bc2_ff, dcv_cb2_ff, dcv_ca2_ff;
   logic signed [DW-1:0] ew2_ff [3];
   logic signed [DW-1:0] ur2_ff [3];
   logic signed [DW-1:0] eu2_ff [3];
   logic signed [DW-1:0] wr2_ff [3];
   logic signed [DW-1:0] vd2_in [3];
   logic signed [DW-1:0] ed2_in [3];
   logic [ptds_pkg::QUO_W-1:0]  vd2_ff [3];
   logic [ptds_pkg::EDEN_W-1:0] ed2_ff [3];
   ptds_pkg::vec35_type xn2_ff [4];
   ptds_pkg::vec17_type bv2_ff;

   assign vd2_in[0] = ptds_pkg::dot17(av_ff, av_ff);
   assign vd2_in[1] = ptds_pkg::dot17(bv_ff, bv_ff);
   assign vd2_in[2] = ptds_pkg::dot17(cv_ff, cv_ff);
   assign ed2_in[0] = ptds_pkg::dot17(ab_ff, ab_ff);
   assign ed2_in[1] = ptds_pkg::dot17(bc_ff, bc_ff);
   assign ed2_in[2] = ptds_pkg::dot17(ca_ff, ca_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         dav_ac2_ff <= ptds_pkg::dot17(av_ff, ac_ff);
         dav_ab2_ff <= ptds_pkg::dot17(av_ff, ab_ff);
         dbv_ba2_ff <= ptds_pkg::dot17(bv_ff, ba_ff);
         dbv_bc2_ff <= ptds_pkg::dot17(bv_ff, bc_ff);
         dcv_cb2_ff <= ptds_pkg::dot17(cv_ff, cb_ff);
         dcv_ca2_ff <= ptds_pkg::dot17(cv_ff, ca_ff);
         ew2_ff[0]  <= ptds_pkg::dot17(ba_ff, ba_ff);
         ur2_ff[0]  <= ptds_pkg::dot17(bc_ff, bv_ff);
         eu2_ff[0]  <= ptds_pkg::dot17(ba_ff, bc_ff);
         wr2_ff[0]  <= ptds_pkg::dot17(ba_ff, bv_ff);
         ew2_ff[1]  <= ptds_pkg::dot17(cb_ff, ba_ff);
         ur2_ff[1]  <= ptds_pkg::dot17(bc_ff, cv_ff);
         eu2_ff[1]  <= ptds_pkg::dot17(cb_ff, bc_ff);
         wr2_ff[1]  <= ptds_pkg::dot17(ba_ff, cv_ff);
         ew2_ff[2]  <= ptds_pkg::dot17(ac_ff, ba_ff);
         ur2_ff[2]  <= ptds_pkg::dot17(bc_ff, av_ff);
         eu2_ff[2]  <= ptds_pkg::dot17(ac_ff, bc_ff);
         wr2_ff[2]  <= ptds_pkg::dot17(ba_ff, av_ff);
         for (int i = 0; i < 3; i++) begin
            vd2_ff[i] <= vd2_in[i][ptds_pkg::QUO_W-1:0];
            ed2_ff[i] <= ed2_in[i][ptds_pkg::EDEN_W-1:0];
         end
         xn2_ff[0] <= ptds_pkg::cross17(av_ff, ab_ff);
         xn2_ff[1] <= ptds_pkg::cross17(bv_ff, bc_ff);
         xn2_ff[2] <= ptds_pkg::cross17(cv_ff, ca_ff);
         xn2_ff[3] <= ptds_pkg::cross17(bc_ff, ba_ff);
         bv2_ff    <= bv_ff;
      end
   end

   // Stage 3: edge side products, squares, region conditions and n . bv.
   logic signed [ptds_pkg::OE_W-1:0] pl3_ff [3];
   logic signed [ptds_pkg::OE_W-1:0] pr3_ff [3];
   logic [ptds_pkg::SQ_W-1:0] sq3_ff [4][3];
   logic [ptds_pkg::QUO_W-1:0]  vd3_ff [3];
   logic [ptds_pkg::EDEN_W-1:0] ed3_ff [3];
   logic vtx3_ff [3];
   logic edg3_ff [3];
   logic signed [ptds_pkg::T_W-1:0] t3_ff;
   logic signed [ptds_pkg::T_W-1:0] tp3 [3];
   logic [ptds_pkg::MAG_W-1:0] mg3 [4][3];

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         for (int i = 0; i < 3; i++) begin
            mg3[j][i] = ptds_pkg::mag35(xn2_ff[j][i]);
         end
      end
      for (int i = 0; i < 3; i++) begin
         tp3[i] = ptds_pkg::T_W'(xn2_ff[3][i] * bv2_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            pl3_ff[i] <= ew2_ff[i] * ur2_ff[i];
            pr3_ff[i] <= eu2_ff[i] * wr2_ff[i];
            vd3_ff[i] <= vd2_ff[i];
            ed3_ff[i] <= ed2_ff[i];
         end
         for (int j = 0; j < 4; j++) begin
            for (int i = 0; i < 3; i++) begin
               sq3_ff[j][i] <= mg3[j][i] * mg3[j][i];
            end
         end
         vtx3_ff[0] <= (dav_ac2_ff <= 0) && (dav_ab2_ff <= 0);
         vtx3_ff[1] <= (dbv_ba2_ff <= 0) && (dbv_bc2_ff <= 0);
         vtx3_ff[2] <= (dcv_cb2_ff <= 0) && (dcv_ca2_ff <= 0);
         edg3_ff[0] <= (dav_ab2_ff >= 0) && (dbv_ba2_ff >= 0);
         edg3_ff[1] <= (dcv_cb2_ff >= 0) && (dbv_bc2_ff >= 0);
         edg3_ff[2] <= (dcv_ca2_ff >= 0) && (dav_ac2_ff >= 0);
         t3_ff <= tp3[0] + tp3[1] + tp3[2];
      end
   end

   // Stage 4: region choice, sums of squares and split square of t.
   ptds_pkg::region_type region4_ff, region4_in;
   logic [ptds_pkg::SUMSQ_W-1:0] ss4_ff [4];
   logic [ptds_pkg::QUO_W-1:0]  vd4_ff [3];
   logic [ptds_pkg::EDEN_W-1:0] ed4_ff [3];
   logic [2*ptds_pkg::THI_W-1:0] thh4_ff;
   logic [ptds_pkg::THI_W+ptds_pkg::TLO_W-1:0] thl4_ff;
   logic [2*ptds_pkg::TLO_W-1:0] tll4_ff;
   logic signed [ptds_pkg::OE_W:0] oed4 [3];
   logic signed [ptds_pkg::T_W-1:0] tneg4;
   logic [ptds_pkg::TMAG_W-1:0] tm4;
   logic [ptds_pkg::THI_W-1:0] thi4;
   logic [ptds_pkg::TLO_W-1:0] tlo4;
   logic out4 [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         oed4[i] = (ptds_pkg::OE_W+1)'(pl3_ff[i]) - (ptds_pkg::OE_W+1)'(pr3_ff[i]);
         out4[i] = oed4[i][ptds_pkg::OE_W];
      end
      tneg4 = -t3_ff;
      tm4   = t3_ff[ptds_pkg::T_W-1] ? tneg4[ptds_pkg::TMAG_W-1:0]
                                      : t3_ff[ptds_pkg::TMAG_W-1:0];
      thi4  = tm4[ptds_pkg::TMAG_W-1:ptds_pkg::TLO_W];
      tlo4  = tm4[ptds_pkg::TLO_W-1:0];
      if (vtx3_ff[0]) begin
         region4_in = ptds_pkg::REGION_VERT_A;
      end else if (vtx3_ff[1]) begin
         region4_in = ptds_pkg::REGION_VERT_B;
      end else if (vtx3_ff[2]) begin
         region4_in = ptds_pkg::REGION_VERT_C;
      end else if (out4[0] && edg3_ff[0]) begin
         region4_in = ptds_pkg::REGION_EDGE_AB;
      end else if (out4[1] && edg3_ff[1]) begin
         region4_in = ptds_pkg::REGION_EDGE_BC;
      end else if (out4[2] && edg3_ff[2]) begin
         region4_in = ptds_pkg::REGION_EDGE_CA;
      end else begin
         region4_in = ptds_pkg::REGION_FACE;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         region4_ff <= region4_in;
         for (int j = 0; j < 4; j++) begin
            ss4_ff[j] <= ptds_pkg::SUMSQ_W'(sq3_ff[j][0]) + ptds_pkg::SUMSQ_W'(sq3_ff[j][1])
                       + ptds_pkg::SUMSQ_W'(sq3_ff[j][2]);
         end
         for (int i = 0; i < 3; i++) begin
            vd4_ff[i] <= vd3_ff[i];
            ed4_ff[i] <= ed3_ff[i];
         end
         thh4_ff <= thi4 * thi4;
         thl4_ff <= thi4 * tlo4;
         tll4_ff <= tlo4 * tlo4;
      end
   end

   // Stage 5: divide operands for the chosen region.
   logic [ptds_pkg::NUM_W-1:0]   num5_ff, num5_in, tsq5;
   logic [ptds_pkg::SUMSQ_W-1:0] den5_ff, den5_in;
   ptds_pkg::side_type side5_ff, side5_in;

   always_comb begin
      tsq5 = (ptds_pkg::NUM_W'(thh4_ff) << (2 * ptds_pkg::TLO_W))
           + (ptds_pkg::NUM_W'(thl4_ff) << (ptds_pkg::TLO_W + 1))
           + ptds_pkg::NUM_W'(tll4_ff);
      side5_in.region  = region4_ff;
      side5_in.use_fix = 1'b0;
      side5_in.fix     = ptds_pkg::DIST_MAX;
      num5_in = '0;
      den5_in = '0;
      case (region4_ff)
         ptds_pkg::REGION_VERT_A: begin
            side5_in.use_fix = 1'b1;
            side5_in.fix     = vd4_ff[0];
         end
         ptds_pkg::REGION_VERT_B: begin
            side5_in.use_fix = 1'b1;
            side5_in.fix     = vd4_ff[1];
         end
         ptds_pkg::REGION_VERT_C: begin
            side5_in.use_fix = 1'b1;
            side5_in.fix     = vd4_ff[2];
         end
         ptds_pkg::REGION_EDGE_AB: begin
            num5_in = ptds_pkg::NUM_W'(ss4_ff[0]);
            den5_in = ptds_pkg::SUMSQ_W'(ed4_ff[0]);
         end
         ptds_pkg::REGION_EDGE_BC: begin
            num5_in = ptds_pkg::NUM_W'(ss4_ff[1]);
            den5_in = ptds_pkg::SUMSQ_W'(ed4_ff[1]);
         end
         ptds_pkg::REGION_EDGE_CA: begin
            num5_in = ptds_pkg::NUM_W'(ss4_ff[2]);
            den5_in = ptds_pkg::SUMSQ_W'(ed4_ff[2]);
         end
         default: begin
            num5_in = tsq5;
            den5_in = ss4_ff[3];
         end
      endcase
      side5_in.deg = !side5_in.use_fix && (den5_in == '0);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         num5_ff  <= num5_in;
         den5_ff  <= den5_in;
         side5_ff <= side5_in;
      end
   end

   // Stage 6: an oversized quotient, or a zero divisor, gives the maximum.
   logic [ptds_pkg::NUM_W-1:0]   num6_ff;
   logic [ptds_pkg::SUMSQ_W-1:0] den6_ff;
   ptds_pkg::side_type side6_ff, side6_in;
   logic sat6;

   always_comb begin
      sat6     = num5_ff >= (ptds_pkg::NUM_W'(den5_ff) << ptds_pkg::QUO_W);
      side6_in = side5_ff;
      if (!side5_ff.use_fix && sat6) begin
         side6_in.use_fix = 1'b1;
         side6_in.fix     = ptds_pkg::DIST_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         num6_ff  <= num5_ff;
         den6_ff  <= den5_ff;
         side6_ff <= side6_in;
      end
   end

   // Restoring divider, one quotient bit per stage, most significant first.
   logic [ptds_pkg::NUM_W-1:0]   rem_ff [ptds_pkg::QUO_W];
   logic [ptds_pkg::NUM_W-1:0]   rem_in [ptds_pkg::QUO_W];
   logic [ptds_pkg::NUM_W-1:0]   rem_src [ptds_pkg::QUO_W];
   logic [ptds_pkg::NUM_W-1:0]   shd [ptds_pkg::QUO_W];
   logic [ptds_pkg::SUMSQ_W-1:0] dden_ff [ptds_pkg::QUO_W];
   logic [ptds_pkg::SUMSQ_W-1:0] dden_src [ptds_pkg::QUO_W];
   logic [ptds_pkg::QUO_W-1:0]   quo_ff [ptds_pkg::QUO_W];
   logic [ptds_pkg::QUO_W-1:0]   quo_in [ptds_pkg::QUO_W];
   logic [ptds_pkg::QUO_W-1:0]   quo_src [ptds_pkg::QUO_W];
   ptds_pkg::side_type dside_ff [ptds_pkg::QUO_W];
   ptds_pkg::side_type dside_src [ptds_pkg::QUO_W];

   always_comb begin
      rem_src[0]   = num6_ff;
      dden_src[0]  = den6_ff;
      quo_src[0]   = '0;
      dside_src[0] = side6_ff;
      for (int k = 1; k < ptds_pkg::QUO_W; k++) begin
         rem_src[k]   = rem_ff[k-1];
         dden_src[k]  = dden_ff[k-1];
         quo_src[k]   = quo_ff[k-1];
         dside_src[k] = dside_ff[k-1];
      end
      for (int k = 0; k < ptds_pkg::QUO_W; k++) begin
         shd[k]    = ptds_pkg::NUM_W'(dden_src[k]) << (ptds_pkg::QUO_W - 1 - k);
         rem_in[k] = rem_src[k];
         quo_in[k] = quo_src[k];
         if (rem_src[k] >= shd[k]) begin
            rem_in[k] = rem_src[k] - shd[k];
            quo_in[k][ptds_pkg::QUO_W-1-k] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < ptds_pkg::QUO_W; k++) begin
            rem_ff[k]   <= rem_in[k];
            dden_ff[k]  <= dden_src[k];
            quo_ff[k]   <= quo_in[k];
            dside_ff[k] <= dside_src[k];
         end
      end
   end

   ptds_pkg::side_type last_side;
   logic [ptds_pkg::QUO_W-1:0] last_dist;

   assign last_side = dside_ff[ptds_pkg::QUO_W-1];
   assign last_dist = last_side.use_fix ? last_side.fix : quo_ff[ptds_pkg::QUO_W-1];
   assign rsp_tdata = {2'b00, last_side.deg, last_side.region, last_dist};

endmodule

`default_nettype wire
